>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> hw/rtl/thp_pkg.sv
// Shared constants, types and helpers of the projection histogram.
// No dependencies.
package thp_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CPOS_W      = COL_W + 1;
    localparam int CMP_W       = 14;

    localparam int PIX_W    = 8;
    localparam int SUB_W    = 4;
    localparam int CEN_W    = 11;
    localparam int ROWS_W   = 11;
    localparam int BCOL_W   = 10;
    localparam int ROWNUM_W = 10;
    localparam int CNT_W    = 11;
    localparam int TOT_W    = 21;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = OUT_DATA_W - (ROWNUM_W + 2 * CNT_W + 2 * TOT_W);

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FLVL_W     = FPTR_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    localparam logic [PIX_W-1:0]  THRESHOLD_RST = 8'hef;
    localparam logic [SUB_W-1:0]  SUBSAMPLE_RST = 4'h1;
    localparam logic [CEN_W-1:0]  CENTER_RST    = 11'd512;
    localparam logic [ROWS_W-1:0] ROWS_RST      = 11'd1024;

    typedef enum logic [1:0] {
        MODE_PIXEL = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_SUBSAMPLE = 2'd1,
        CFG_CENTER    = 2'd2,
        CFG_ROWS      = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        KIND_ROW = 1'b0,
        KIND_BIN = 1'b1
    } kind_t;

    typedef struct packed {
        logic             tag;
        logic [CNT_W-1:0] cnt;
    } bin_ent_t;

    typedef struct packed {
        logic             hit;
        logic             tag;
        logic [COL_W-1:0] addr;
    } bin_upd_t;

    typedef struct packed {
        kind_t               kind;
        logic [ROWNUM_W-1:0] row_number;
        logic [CNT_W-1:0]    row_hits;
        logic [TOT_W-1:0]    left_count;
        logic [TOT_W-1:0]    right_count;
        logic                frame_done;
        logic [CNT_W-1:0]    bin_value;
    } res_t;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOT_W-1:0] tot_inc(input logic [TOT_W-1:0] v);
        return (v == TOT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

>>> hw/rtl/threshold_projection_histogram.sv
// Top level of the thresholded projection histogram.
// Depends on thp_pkg, thp_bin_mem, thp_out_fifo and assert_macros.svh.
//
// Pixel, frame-start and bin-read words enter on the s_ group, mode in
// s_tuser, end of row in s_tlast. Row reports and bin reads leave on the m_
// group, kind in m_tuser, frame done in m_tlast. Registers are set through
// cfg_we/cfg_index/cfg_data while no word is in flight.
// Throughput: one word per cycle while s_tready is high. A result passes the
// update-stage register and the queue before it is valid on m_ (bin RAM read
// at the intake edge, read-modify-write and queue push in the next cycle).
// Scalar counters update at intake; the bin count and its frame tag are the
// only state in the RAM, with the last write forwarded to the next read.
// After reset s_tready stays low while the bin RAM is swept to zero;
// configuration writes are taken during that time.
// A four-word queue holds results; after the sweep, s_tready drops only when
// the queue plus the word in the update stage would fill it, so a stalled
// receiver stops intake without losing or repeating words.
`include "assert_macros.svh"
module threshold_projection_histogram (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] pixel, [17:8] bin_column, [23:18] zero
    input  logic [thp_pkg::IN_DATA_W-1:0]       s_tdata,
    // [1:0] mode
    input  logic [1:0]                          s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [9:0] row_number, [20:10] row_hits, [41:21] left_count,
    // [62:42] right_count, [73:63] bin_value, [79:74] zero
    output logic [thp_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [0] result_kind
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [thp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [thp_pkg::CFG_W-1:0]           cfg_data
);

    logic [thp_pkg::PIX_W-1:0]     thr_reg;
    logic [thp_pkg::SUB_W-1:0]     sub_reg;
    logic [thp_pkg::CEN_W-1:0]     center_reg;
    logic [thp_pkg::ROWS_W-1:0]    rows_reg;

    logic [thp_pkg::CPOS_W-1:0]    col_pos_reg,  col_pos_next;
    logic [thp_pkg::SUB_W-1:0]     phase_reg,    phase_next;
    logic [thp_pkg::CNT_W-1:0]     row_pos_reg,  row_pos_next;
    logic [thp_pkg::CNT_W-1:0]     row_hit_reg,  row_hit_next;
    logic [thp_pkg::TOT_W-1:0]     left_reg,     left_next;
    logic [thp_pkg::TOT_W-1:0]     right_reg,    right_next;
    logic                          frame_cpl_reg, frame_cpl_next;
    logic                          tag_reg,      tag_next;

    logic                          s1_vld_reg,   s1_vld_next;
    thp_pkg::res_t                 s1_res_reg,   s1_res_next;
    thp_pkg::bin_upd_t             s1_upd_reg,   s1_upd_next;
    logic                          s1_inr_reg,   s1_inr_next;

    thp_pkg::mode_t                mode;
    logic [thp_pkg::PIX_W-1:0]     pixel;
    logic [thp_pkg::BCOL_W-1:0]    bcol;
    logic                          acc;
    logic                          pix_en;
    logic                          col_ok;
    logic                          hit;
    logic [thp_pkg::SUB_W-1:0]     sub_eff;
    logic [thp_pkg::SUB_W:0]       nphase;
    logic [thp_pkg::CMP_W-1:0]     rows_eff;
    logic                          done;
    logic [thp_pkg::CNT_W-1:0]     hit_cnt;
    logic [thp_pkg::TOT_W-1:0]     left_cnt;
    logic [thp_pkg::TOT_W-1:0]     right_cnt;

    logic [thp_pkg::CNT_W-1:0]     bin_cnt;
    logic                          clearing;
    thp_pkg::res_t                 s1_out;
    thp_pkg::res_t                 q_data;
    logic [thp_pkg::FLVL_W-1:0]    q_level;
    logic [thp_pkg::FLVL_W:0]      pending;

    assign mode  = thp_pkg::mode_t'(s_tuser);
    assign pixel = s_tdata[thp_pkg::PIX_W-1:0];
    assign bcol  = s_tdata[thp_pkg::PIX_W +: thp_pkg::BCOL_W];
    assign acc   = s_tvalid && s_tready;

    assign pending  = (thp_pkg::FLVL_W + 1)'(q_level) + (thp_pkg::FLVL_W + 1)'(s1_vld_reg);
    assign s_tready = !clearing && (pending < (thp_pkg::FLVL_W + 1)'(thp_pkg::FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= thp_pkg::THRESHOLD_RST;
            sub_reg    <= thp_pkg::SUBSAMPLE_RST;
            center_reg <= thp_pkg::CENTER_RST;
            rows_reg   <= thp_pkg::ROWS_RST;
        end
        else if (cfg_we)
        begin
            unique case (thp_pkg::cfg_idx_t'(cfg_index))
                thp_pkg::CFG_THRESHOLD: thr_reg    <= cfg_data[thp_pkg::PIX_W-1:0];
                thp_pkg::CFG_SUBSAMPLE: sub_reg    <= cfg_data[thp_pkg::SUB_W-1:0];
                thp_pkg::CFG_CENTER:    center_reg <= cfg_data[thp_pkg::CEN_W-1:0];
                thp_pkg::CFG_ROWS:      rows_reg   <= cfg_data[thp_pkg::ROWS_W-1:0];
            endcase
        end
    end

    // intake stage: scan position, hit decision and scalar counters
    always_comb
    begin
        col_ok  = thp_pkg::CMP_W'(col_pos_reg) < thp_pkg::CMP_W'(thp_pkg::MAX_COLUMNS);
        pix_en  = acc && (mode == thp_pkg::MODE_PIXEL) && !frame_cpl_reg;
        hit     = pix_en && (phase_reg == '0) && col_ok && (pixel > thr_reg);
        sub_eff = (sub_reg == '0) ? thp_pkg::SUB_W'(1) : sub_reg;
        nphase  = {1'b0, phase_reg} + 1'b1;

        if (rows_reg == '0)
        begin
            rows_eff = thp_pkg::CMP_W'(1);
        end
        else if (thp_pkg::CMP_W'(rows_reg) > thp_pkg::CMP_W'(thp_pkg::MAX_ROWS))
        begin
            rows_eff = thp_pkg::CMP_W'(thp_pkg::MAX_ROWS);
        end
        else
        begin
            rows_eff = thp_pkg::CMP_W'(rows_reg);
        end
        done = (thp_pkg::CMP_W'(row_pos_reg) + 1'b1) >= rows_eff;

        hit_cnt   = hit ? thp_pkg::cnt_inc(row_hit_reg) : row_hit_reg;
        left_cnt  = left_reg;
        right_cnt = right_reg;
        if (hit && (thp_pkg::CMP_W'(col_pos_reg) < thp_pkg::CMP_W'(center_reg)))
        begin
            left_cnt = thp_pkg::tot_inc(left_reg);
        end
        else if (hit)
        begin
            right_cnt = thp_pkg::tot_inc(right_reg);
        end

        col_pos_next   = col_pos_reg;
        phase_next     = phase_reg;
        row_pos_next   = row_pos_reg;
        row_hit_next   = row_hit_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        frame_cpl_next = frame_cpl_reg;
        tag_next       = tag_reg;

        if (pix_en)
        begin
            col_pos_next = col_ok ? col_pos_reg + 1'b1 : col_pos_reg;
            phase_next   = (nphase >= {1'b0, sub_eff}) ? '0 : nphase[thp_pkg::SUB_W-1:0];
            row_hit_next = hit_cnt;
            left_next    = left_cnt;
            right_next   = right_cnt;
            if (s_tlast)
            begin
                row_pos_next   = thp_pkg::cnt_inc(row_pos_reg);
                frame_cpl_next = done;
                col_pos_next   = '0;
                phase_next     = '0;
                row_hit_next   = '0;
            end
        end
        else if (acc && (mode == thp_pkg::MODE_FRAME))
        begin
            tag_next       = !tag_reg;
            col_pos_next   = '0;
            phase_next     = '0;
            row_pos_next   = '0;
            row_hit_next   = '0;
            left_next      = '0;
            right_next     = '0;
            frame_cpl_next = 1'b0;
        end
    end

    always_comb
    begin
        s1_vld_next = (pix_en && s_tlast) || (acc && (mode == thp_pkg::MODE_READ));

        s1_res_next             = '0;
        s1_res_next.kind        = (mode == thp_pkg::MODE_READ) ? thp_pkg::KIND_BIN
                                                               : thp_pkg::KIND_ROW;
        if (mode != thp_pkg::MODE_READ)
        begin
            s1_res_next.row_number  = row_pos_reg[thp_pkg::ROWNUM_W-1:0];
            s1_res_next.row_hits    = hit_cnt;
            s1_res_next.left_count  = left_cnt;
            s1_res_next.right_count = right_cnt;
            s1_res_next.frame_done  = done;
        end

        s1_inr_next      = thp_pkg::CMP_W'(bcol) < thp_pkg::CMP_W'(thp_pkg::MAX_COLUMNS);
        s1_upd_next.hit  = hit;
        s1_upd_next.tag  = tag_reg;
        s1_upd_next.addr = (mode == thp_pkg::MODE_READ) ? thp_pkg::COL_W'(bcol)
                                                        : thp_pkg::COL_W'(col_pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg   <= '0;
            phase_reg     <= '0;
            row_pos_reg   <= '0;
            row_hit_reg   <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            frame_cpl_reg <= 1'b0;
            tag_reg       <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s1_upd_reg    <= '0;
        end
        else
        begin
            col_pos_reg   <= col_pos_next;
            phase_reg     <= phase_next;
            row_pos_reg   <= row_pos_next;
            row_hit_reg   <= row_hit_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            frame_cpl_reg <= frame_cpl_next;
            tag_reg       <= tag_next;
            s1_vld_reg    <= s1_vld_next;
            s1_upd_reg    <= s1_upd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_res_reg <= s1_res_next;
        s1_inr_reg <= s1_inr_next;
    end

    thp_bin_mem u_bin_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (acc),
        .rd_addr  (s1_upd_next.addr),
        .upd      (s1_upd_reg),
        .cnt      (bin_cnt),
        .clearing (clearing)
    );

    always_comb
    begin
        s1_out = s1_res_reg;
        if (s1_res_reg.kind == thp_pkg::KIND_BIN)
        begin
            s1_out.bin_value = s1_inr_reg ? bin_cnt : '0;
        end
    end

    thp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_vld_reg),
        .push_data (s1_out),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (q_data),
        .level     (q_level)
    );

    assign m_tdata = {{thp_pkg::OUT_PAD_W{1'b0}}, q_data.bin_value, q_data.right_count,
                      q_data.left_count, q_data.row_hits, q_data.row_number};
    assign m_tuser = q_data.kind;
    assign m_tlast = q_data.frame_done;

    `ASSERT_NEVER(a_no_intake_in_clear, clk, rst_n, s_tvalid && s_tready && clearing)
    `ASSERT_PROP(a_done_sets_complete, clk, rst_n,
        s1_vld_reg && (s1_res_reg.kind == thp_pkg::KIND_ROW) && s1_res_reg.frame_done
        |-> frame_cpl_reg)
    `ASSERT_PROP(a_no_report_after_done, clk, rst_n,
        s_tvalid && s_tready && (s_tuser == thp_pkg::MODE_PIXEL) && frame_cpl_reg
        |=> !s1_vld_reg)
    `ASSERT_NEVER(a_hit_only_when_sampled, clk, rst_n, hit && (phase_reg != '0))

endmodule

>>> hw/rtl/thp_bin_mem.sv
// Column bin memory: registered read, read-modify-write of the bin count,
// write forwarding and the clearing pass after reset. Depends on thp_pkg.
module thp_bin_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [thp_pkg::COL_W-1:0]  rd_addr,
    input  thp_pkg::bin_upd_t          upd,
    output logic [thp_pkg::CNT_W-1:0]  cnt,
    output logic                       clearing
);

    thp_pkg::bin_ent_t mem [thp_pkg::MAX_COLUMNS];

    thp_pkg::bin_ent_t              rdata_reg;
    logic                           fwd_vld_reg;
    logic [thp_pkg::COL_W-1:0]      fwd_addr_reg;
    thp_pkg::bin_ent_t              fwd_ent_reg;
    logic [thp_pkg::COL_W:0]        clr_cnt_reg;
    logic [thp_pkg::COL_W:0]        clr_cnt_next;

    thp_pkg::bin_ent_t              ent;
    thp_pkg::bin_ent_t              wd;
    logic [thp_pkg::COL_W-1:0]      wa;
    logic                           we;

    assign clearing = !clr_cnt_reg[thp_pkg::COL_W];

    always_comb
    begin
        // a write at the same edge as this entry's read is missed by the RAM
        ent = (fwd_vld_reg && (fwd_addr_reg == upd.addr)) ? fwd_ent_reg : rdata_reg;
        cnt = (ent.tag == upd.tag) ? ent.cnt : '0;
        clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        we = clearing || upd.hit;
        wa = clearing ? clr_cnt_reg[thp_pkg::COL_W-1:0] : upd.addr;
        if (clearing)
        begin
            wd = '0;
        end
        else
        begin
            wd.tag = upd.tag;
            wd.cnt = thp_pkg::cnt_inc(cnt);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        fwd_addr_reg <= wa;
        fwd_ent_reg  <= wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            fwd_vld_reg <= we;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

endmodule

>>> hw/rtl/thp_out_fifo.sv
// Result word queue in front of the master port.
// Depends on thp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module thp_out_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  thp_pkg::res_t               push_data,
    input  logic                        pop_ready,
    output logic                        out_valid,
    output thp_pkg::res_t               out_data,
    output logic [thp_pkg::FLVL_W-1:0]  level
);

    thp_pkg::res_t                 buf_mem [thp_pkg::FIFO_DEPTH];
    logic [thp_pkg::FPTR_W-1:0]    wr_ptr_reg;
    logic [thp_pkg::FPTR_W-1:0]    rd_ptr_reg;
    logic [thp_pkg::FLVL_W-1:0]    level_reg;
    logic                          pop;

    assign out_valid = (level_reg != '0);
    assign out_data  = buf_mem[rd_ptr_reg];
    assign level     = level_reg;
    assign pop       = out_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_fifo_overflow, clk, rst_n,
        push && !pop && (level_reg == thp_pkg::FLVL_W'(thp_pkg::FIFO_DEPTH)))

endmodule
